// File: rtl/core/lmss_pkg.sv
// Shared types and constants for the LED matrix scroll scanner.
package lmss_pkg;

    localparam int STORE_COLUMNS  = 32;
    localparam int MATRIX_COLUMNS = 8;
    localparam int STORE_ADDR_W   = $clog2(STORE_COLUMNS);
    localparam int COL_W          = $clog2(MATRIX_COLUMNS);
    localparam int DRIVE_W        = 8;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_IDX_W      = 2;

    localparam logic [15:0] DWELL_RESET  = 16'd2500;
    localparam logic [15:0] REPEAT_RESET = 16'd1;
    localparam logic [4:0]  WINDOW_RESET = 5'd25;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_START = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DWELL   = 2'd0,
        CFG_REPEAT  = 2'd1,
        CFG_SCROLL  = 2'd2,
        CFG_WINDOWS = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] dwell_ticks;
        logic [15:0] repeat_count;
        logic        scroll_mode;
        logic [4:0]  window_count;
    } t_cfg;

    typedef struct packed {
        logic [1:0] cmd;
        logic [4:0] column_addr;
        logic [7:0] column_bits;
    } t_in_item;

    typedef struct packed {
        logic [7:0] row_drive;
        logic [7:0] column_drive_n;
        logic       scanning;
        logic       scroll_done;
    } t_out_item;

    // Scan state as it stands after the item being accepted
    typedef struct packed {
        logic             run;
        logic             done;
        logic [COL_W-1:0] col;
        logic [4:0]       offset;
    } t_scan_view;

endpackage

// File: rtl/core/lmss_scan_ctrl.sv
// Scan sequencer: dwell, column, frame and window counters.
module lmss_scan_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_acc,
    input  lmss_pkg::t_cmd       i_cmd,
    input  lmss_pkg::t_cfg       i_cfg,
    output lmss_pkg::t_scan_view o_next
);
    import lmss_pkg::*;

    logic [COL_W-1:0] r_col,    n_col;
    logic [15:0]      r_dwell,  n_dwell;
    logic [15:0]      r_frames, n_frames;
    logic [4:0]       r_offset, n_offset;
    logic             r_run,    n_run;
    logic             r_done,   n_done;

    logic [16:0]      dwell_inc;
    logic [16:0]      frames_inc;
    logic [COL_W:0]   col_inc;
    logic [5:0]       offset_inc;
    logic [15:0]      dwell_limit;
    logic [4:0]       windows;

    always_comb begin
        n_col      = r_col;
        n_dwell    = r_dwell;
        n_frames   = r_frames;
        n_offset   = r_offset;
        n_run      = r_run;
        n_done     = r_done;
        dwell_inc  = {1'b0, r_dwell} + 17'd1;
        frames_inc = {1'b0, r_frames} + 17'd1;
        col_inc    = {1'b0, r_col} + (COL_W+1)'(1);
        offset_inc = {1'b0, r_offset} + 6'd1;
        dwell_limit = (i_cfg.dwell_ticks == 16'd0) ? 16'd1 : i_cfg.dwell_ticks;
        windows     = (i_cfg.window_count == 5'd0) ? 5'd1 : i_cfg.window_count;
        case (i_cmd)
            CMD_TICK: begin
                if (r_run) begin
                    if (dwell_inc < {1'b0, dwell_limit}) begin
                        n_dwell = dwell_inc[15:0];
                    end else begin
                        n_dwell = 16'd0;
                        if (col_inc >= (COL_W+1)'(MATRIX_COLUMNS)) begin
                            n_col = '0;
                            if (i_cfg.scroll_mode) begin
                                if (frames_inc >= {1'b0, i_cfg.repeat_count}) begin
                                    n_frames = 16'd0;
                                    n_offset = offset_inc[4:0];
                                    if (offset_inc >= {1'b0, windows}) begin
                                        n_run  = 1'b0;
                                        n_done = 1'b1;
                                    end
                                end else begin
                                    n_frames = frames_inc[15:0];
                                end
                            end
                        end else begin
                            n_col = col_inc[COL_W-1:0];
                        end
                    end
                end
            end
            CMD_START: begin
                n_col    = '0;
                n_dwell  = 16'd0;
                n_frames = 16'd0;
                n_offset = 5'd0;
                n_done   = 1'b0;
                n_run    = 1'b1;
                // zero repeat count in scroll mode ends the scroll right away
                if (i_cfg.scroll_mode && i_cfg.repeat_count == 16'd0) begin
                    n_run  = 1'b0;
                    n_done = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_dwell  <= 16'd0;
            r_frames <= 16'd0;
            r_offset <= 5'd0;
            r_run    <= 1'b0;
            r_done   <= 1'b0;
        end else if (i_acc) begin
            r_col    <= n_col;
            r_dwell  <= n_dwell;
            r_frames <= n_frames;
            r_offset <= n_offset;
            r_run    <= n_run;
            r_done   <= n_done;
        end
    end

    assign o_next = '{run: n_run, done: n_done, col: n_col, offset: n_offset};

    a_run_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_run && r_done))
        else $error("scan running and done at once");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && i_cmd == CMD_START) |=> (r_col == '0 && r_dwell == 16'd0))
        else $error("start did not rewind the scan");

    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && i_cmd == CMD_TICK && !r_run) |=> $stable(r_dwell) && !r_run)
        else $error("tick changed a stopped scan");

endmodule

// File: rtl/core/led_matrix_scroll_scanner_top.sv
// Top level of the LED matrix scroll scanner: pattern store and result pipeline.
//
// Usage: items enter on the i_in_* valid/ready channel. Each item is a pattern
// write, a time tick, a start or a no-op, and yields exactly one result on the
// o_out_* channel: row drive, active-low column drive, scanning and done flags
// as they stand after that item.
// Configuration registers (dwell, repeat count, scroll mode, window count) are
// written through i_cfg_we / i_cfg_idx / i_cfg_data, one per cycle, no wait.
// Each result passes through the read stage (the pattern store is read at the
// transfer edge) and then the output register, which loads once it has room.
// Throughput: one item per cycle while the receiver takes results, set by the
// single store read port and the counter update.
// Stalls: the output register and the read stage each hold one item; input
// stays ready while either has room or the receiver is taking the result.
// Reset (synchronous, active low) stops the scan, clears the done flag, loads
// the default configuration and marks every store column as zero through
// per-column valid bits, so no clearing pass is needed.
module led_matrix_scroll_scanner_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  lmss_pkg::t_in_item                    i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output lmss_pkg::t_out_item                   o_out_data,
    input  logic                                  i_cfg_we,
    input  logic [lmss_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [lmss_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import lmss_pkg::*;

    t_cfg        r_cfg;
    t_scan_view  scan_next;
    logic        acc;
    logic        wr;
    logic [STORE_ADDR_W-1:0] wr_addr;
    logic [STORE_ADDR_W-1:0] rd_slot;
    logic [5:0]  slot_sum;

    logic [7:0]  r_mem [STORE_COLUMNS];
    logic [STORE_COLUMNS-1:0] r_col_vld;
    logic [7:0]  r_rdata;

    // read stage
    logic        r_s1_valid;
    logic        r_s1_fwd;
    logic [7:0]  r_s1_fwd_data;
    logic        r_s1_entry_vld;
    t_scan_view  r_s1_view;
    logic        s1_move;
    t_out_item   s1_item;
    logic [7:0]  s1_byte;

    logic        r_out_valid;
    t_out_item   r_out_data;
    logic        out_load;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{dwell_ticks: DWELL_RESET, repeat_count: REPEAT_RESET,
                       scroll_mode: 1'b0, window_count: WINDOW_RESET};
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DWELL:   r_cfg.dwell_ticks  <= i_cfg_data;
                CFG_REPEAT:  r_cfg.repeat_count <= i_cfg_data;
                CFG_SCROLL:  r_cfg.scroll_mode  <= i_cfg_data[0];
                CFG_WINDOWS: r_cfg.window_count <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // handshake
    assign out_load   = !r_out_valid || i_out_ready;
    assign s1_move    = r_s1_valid && out_load;
    assign o_in_ready = !r_s1_valid || s1_move;
    assign acc        = i_in_valid && o_in_ready;

    lmss_scan_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_cmd   (t_cmd'(i_in_data.cmd)),
        .i_cfg   (r_cfg),
        .o_next  (scan_next)
    );

    // store address after the item; store depth is a power of two
    assign slot_sum = {1'b0, scan_next.offset} + 6'(scan_next.col);
    assign rd_slot  = slot_sum[STORE_ADDR_W-1:0];
    assign wr_addr  = STORE_ADDR_W'(i_in_data.column_addr);
    assign wr       = acc && t_cmd'(i_in_data.cmd) == CMD_WRITE
                      && 32'(i_in_data.column_addr) < STORE_COLUMNS;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[wr_addr] <= i_in_data.column_bits;
        end
        if (acc) begin
            r_rdata <= r_mem[rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_vld <= '0;
        end else if (wr) begin
            r_col_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // the read sees old contents when the same column is written this cycle
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_view      <= scan_next;
            r_s1_fwd       <= wr && wr_addr == rd_slot;
            r_s1_fwd_data  <= i_in_data.column_bits;
            r_s1_entry_vld <= r_col_vld[rd_slot];
        end
    end

    always_comb begin
        if (r_s1_fwd) begin
            s1_byte = r_s1_fwd_data;
        end else if (r_s1_entry_vld) begin
            s1_byte = r_rdata;
        end else begin
            s1_byte = 8'd0;
        end
        s1_item.row_drive   = r_s1_view.run ? s1_byte : 8'd0;
        s1_item.scanning    = r_s1_view.run;
        s1_item.scroll_done = r_s1_view.done;
        for (int b = 0; b < DRIVE_W; b++) begin
            s1_item.column_drive_n[b] = !(r_s1_view.run
                                          && 32'(r_s1_view.col) == b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_data <= s1_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_one_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(~o_out_data.column_drive_n))
        else $error("more than one column driven");

    a_blank_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.scanning) |->
        (o_out_data.row_drive == 8'd0 && o_out_data.column_drive_n == 8'hFF))
        else $error("display not blank while stopped");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.scanning && o_out_data.scroll_done))
        else $error("scanning and done both set");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |=> r_s1_valid)
        else $error("read stage lost an item");

endmodule
